### sv/sorted_list_insert_delete_top_assert.svh
// ---------------------------------------------------------------------------
// Sorted list assertion macros
// Concurrent assertion wrappers for the sorted list block; define
// NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SLI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLI_ASSERT_SAME(lbl, ante, cons, msg)
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/sli_pkg.sv
// ---------------------------------------------------------------------------
// Sorted list package
// Payload types, status codes and cell control for the sorted list block.
// ---------------------------------------------------------------------------
package sli_pkg;

  localparam int SLI_CAPACITY = 16;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              cmd;
    logic signed [7:0] value;
  } sli_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] count;
  } sli_out_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              eval;
    logic              do_ins;
    logic              do_del;
    logic signed [7:0] value;
  } cell_ctl_t;

endpackage

### sv/sli_cell.sv
// ---------------------------------------------------------------------------
// Sorted list cell
// One list slot: compares the broadcast value with its entry, then either
// holds, takes the new value, or takes a neighbor's entry.
// ---------------------------------------------------------------------------
module sli_cell import sli_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              occ,
  input  logic signed [7:0] left_val,
  input  logic              left_at,
  input  logic signed [7:0] right_val,
  output logic signed [7:0] val,
  output logic              ins_at,
  output logic              eq
);

  logic signed [7:0] val_r;
  logic              ge_r;
  logic              occ_r;
  logic              eq_r;
  logic              flag_vld_r;

  // Sorted order makes "value <= entry" monotone, so no prefix chain is needed
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      ge_r  <= ctl.value <= val_r;
      occ_r <= occ;
      eq_r  <= occ && (val_r == ctl.value);
    end
    if (ctl.do_ins && ins_at) begin
      val_r <= left_at ? left_val : ctl.value;
    end else if (ctl.do_del && occ_r && ge_r) begin
      val_r <= right_val;
    end
  end

  // Flags are meaningless until the first compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_vld_r <= 1'b0;
    end else if (ctl.eval) begin
      flag_vld_r <= 1'b1;
    end
  end

  assign val    = val_r;
  assign ins_at = flag_vld_r && (!occ_r || ge_r);
  assign eq     = flag_vld_r && eq_r;

endmodule

### sv/sorted_list_insert_delete_top.sv
// ---------------------------------------------------------------------------
// Sorted list insert/delete
// Bounded ascending list of signed 8-bit values held in a chain of cells.
//
//   channel  direction  payload     handshake
//   in_      input      sli_in_t    in_valid / in_stall
//   out_     output     sli_out_t   out_valid / out_stall
//
// An item is handled in order: accept, compare in every cell, shift the chain.
// The shift cycle waits while the output register holds an untaken result.
// Reset clears the state, fill count and output valid; cell contents stay undefined until used.
// in_stall is high from acceptance until the item's result is loaded.
// ---------------------------------------------------------------------------
`include "sorted_list_insert_delete_top_assert.svh"

module sorted_list_insert_delete_top import sli_pkg::*; #(
  parameter int CAPACITY = SLI_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sli_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sli_out_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_APPLY} state_t;

  state_t            state_r;
  logic              cmd_r;
  logic signed [7:0] value_r;
  logic [CNT_W-1:0]  count_r;
  logic              out_valid_r;
  sli_out_t          out_data_r;

  logic signed [7:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_at;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] occ;

  cell_ctl_t        ctl;
  logic             in_fire;
  logic             apply_go;
  logic             found;
  logic             full;
  status_t          status;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W+4:0] count_ext;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || !out_stall);
  assign found    = |cell_eq;
  assign full     = (count_r >= CNT_W'(CAPACITY));

  always_comb begin
    status    = ST_INSERTED;
    count_nxt = count_r;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          status    = ST_INSERTED;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (found) begin
          status    = ST_DELETED;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: status = ST_NOT_FOUND;
    endcase
  end

  assign count_ext = {5'b0, count_nxt};

  assign ctl.eval   = (state_r == S_EVAL);
  assign ctl.do_ins = apply_go && (cmd_r == CMD_INSERT) && !full;
  assign ctl.do_del = apply_go && (cmd_r == CMD_DELETE) && found;
  assign ctl.value  = value_r;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [7:0] left_v;
      logic signed [7:0] right_v;
      logic              left_a;

      assign occ[gi] = CNT_W'(gi) < count_r;

      if (gi == 0) begin : g_first
        assign left_v = cell_val[gi];
        assign left_a = 1'b0;
      end else begin : g_mid
        assign left_v = cell_val[gi-1];
        assign left_a = cell_at[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_v = cell_val[gi];
      end else begin : g_body
        assign right_v = cell_val[gi+1];
      end

      sli_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .occ       (occ[gi]),
        .left_val  (left_v),
        .left_at   (left_a),
        .right_val (right_v),
        .val       (cell_val[gi]),
        .ins_at    (cell_at[gi]),
        .eq        (cell_eq[gi])
      );
    end
  endgenerate

  // Operation registers carry payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_data.cmd;
      value_r <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: state_r <= S_APPLY;
        S_APPLY: begin
          if (apply_go) begin
            count_r    <= count_nxt;
            out_data_r <= '{status: status, count: count_ext[4:0]};
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SLI_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `SLI_ASSERT_NEXT(a_accept_eval, in_fire, state_r == S_EVAL, "accepted item skipped compare")
  `SLI_ASSERT_NEXT(a_full_holds, apply_go && status == ST_FULL, count_r == $past(count_r), "full insert changed count")
  `SLI_ASSERT_NEXT(a_load_valid, apply_go, out_valid_r, "result not presented")

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Sorted list insert/delete testbench
// Drives insert and delete transactions into the sorted list block in random
// bursts while the result side stalls on its own pattern. An internal list
// predicts each status and count, and every result is checked in order.
// ----------------------------------------------------------------------------
module tb_top import sli_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic    drain;
    sli_in_t data;
  } pend_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sli_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sli_out_t out_data;

  pend_t             pend_items[$];
  sli_out_t          exp_results[$];
  logic signed [7:0] live_vals[$];
  logic signed [7:0] plan_vals[$];

  logic     drive_en = 1'b0;
  logic     in_taken = 1'b0;
  logic     nxt_valid;
  sli_in_t  nxt_data;
  int       gap_left = 0;
  int       burst_left = 1;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  int       mode = 0;
  int       mode_left = 0;
  logic     stall_nxt;
  int       results_seen = 0;
  int       fail_count = 0;
  sli_out_t want;

  sorted_list_insert_delete_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one insert or delete to an ascending list; return status and count
  function automatic sli_out_t apply_op(ref logic signed [7:0] vals[$], input sli_in_t op);
    sli_out_t res;
    int       pos;
    pos = 0;
    if (op.cmd == CMD_INSERT) begin
      if (vals.size() >= SLI_CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // land ahead of any equal values
        while (pos < vals.size() && op.value > vals[pos]) pos++;
        vals.insert(pos, op.value);
        res.status = ST_INSERTED;
      end
    end else begin
      while (pos < vals.size() && vals[pos] != op.value) pos++;
      if (pos >= vals.size()) begin
        res.status = ST_NOT_FOUND;
      end else begin
        vals.delete(pos);
        res.status = ST_DELETED;
      end
    end
    res.count = 5'(vals.size());
    return res;
  endfunction

  task automatic queue_op(input cmd_t cmd, input logic signed [7:0] val, input logic drain);
    pend_t p;
    p.drain      = drain;
    p.data.cmd   = cmd;
    p.data.value = val;
    void'(apply_op(plan_vals, p.data));
    pend_items.push_back(p);
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    nxt_valid = in_valid && !in_taken;
    nxt_data  = in_data;
    if (!nxt_valid && drive_en) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_items.size() > 0 &&
                   !(pend_items[0].drain && exp_results.size() > 0)) begin
        nxt_data  = pend_items[0].data;
        nxt_valid = 1'b1;
        void'(pend_items.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // Receiver: stall modes that change over time, plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      stall_nxt = 1'b1;
    end else if (!hold_done && results_seen >= 120) begin
      hold_left = 80;
      hold_done = 1'b1;
      stall_nxt = 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        0: begin
          stall_nxt = 1'b0;
        end
        1: begin
          stall_nxt = ($urandom_range(0, 3) == 0);
        end
        default: begin
          stall_nxt = ($urandom_range(0, 3) != 0);
        end
      endcase
    end
    out_stall <= stall_nxt;
  end

  // Predict on each accepted transaction, check each delivered result
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) exp_results.push_back(apply_op(live_vals, in_data));
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (exp_results.size() == 0) begin
        $display("%0t: unexpected result status %0d count %0d", $realtime,
                 out_data.status, out_data.count);
        fail_count++;
      end else begin
        want = exp_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   want.status, out_data.status);
          fail_count++;
        end
        if (out_data.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $realtime,
                   want.count, out_data.count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int                i;
    int                target;
    logic              ins;
    logic signed [7:0] v;

    // empty-list deletes, extremes, duplicates, delete of zero
    queue_op(CMD_DELETE, 8'sd5, 1'b0);
    queue_op(CMD_DELETE, 8'sd0, 1'b0);
    queue_op(CMD_INSERT, -8'sd128, 1'b0);
    queue_op(CMD_INSERT, 8'sd127, 1'b0);
    queue_op(CMD_INSERT, 8'sd0, 1'b0);
    queue_op(CMD_INSERT, 8'sd0, 1'b0);
    queue_op(CMD_INSERT, -8'sd1, 1'b0);
    queue_op(CMD_INSERT, 8'sd1, 1'b0);
    queue_op(CMD_DELETE, 8'sd0, 1'b0);
    queue_op(CMD_DELETE, 8'sd0, 1'b0);
    queue_op(CMD_DELETE, 8'sd0, 1'b0);
    queue_op(CMD_DELETE, 8'sd127, 1'b0);
    queue_op(CMD_DELETE, -8'sd128, 1'b0);
    // fill to capacity, then overflow
    while (plan_vals.size() < SLI_CAPACITY) queue_op(CMD_INSERT, 8'($urandom_range(0, 255)), 1'b0);
    queue_op(CMD_INSERT, 8'sd42, 1'b0);
    queue_op(CMD_DELETE, 8'sd99, 1'b0);

    // random part: drift the fill level toward a moving target
    target = 8;
    for (i = 0; i < 500; i++) begin
      if (i % 40 == 0) target = $urandom_range(0, SLI_CAPACITY + 2);
      if (plan_vals.size() < target) ins = ($urandom_range(0, 9) < 8);
      else ins = ($urandom_range(0, 9) < 2);
      if (!ins && plan_vals.size() > 0 && $urandom_range(0, 9) < 7)
        v = plan_vals[$urandom_range(0, plan_vals.size() - 1)];
      else if ($urandom_range(0, 1) == 1)
        v = 8'($urandom_range(0, 15) - 8);
      else
        v = 8'($urandom_range(0, 255));
      queue_op(ins ? CMD_INSERT : CMD_DELETE, v, (i == 0 || i == 250));
    end

    repeat (12) @(negedge clk);
    rst_n    <= 1'b1;
    drive_en <= 1'b1;

    while (pend_items.size() > 0 || in_valid || exp_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
